// ===== rtl/framebuffer_line_rasterizer_macros.svh =====
// Assertion macros used by the line rasterizer checker.
`ifndef FRAMEBUFFER_LINE_RASTERIZER_MACROS_SVH
`define FRAMEBUFFER_LINE_RASTERIZER_MACROS_SVH

// Checked only outside reset.
`define FLR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("line rasterizer port check failed");

// Checked at every edge, reset included.
`define FLR_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("line rasterizer reset check failed");

`endif

// ===== rtl/flr_pkg.sv =====
// Types, codes and controller/datapath interface of the line rasterizer.
package flr_pkg;

   localparam int COORD_W   = 12;
   localparam int DIFF_W    = 13;
   localparam int WIDE_W    = 15;
   localparam int CHAN_W    = 8;
   localparam int COLOR_W   = 24;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic [COLOR_W-1:0]        color_type;
   typedef logic [MODE_W-1:0]         mode_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;
   typedef logic [1:0]                kind_type;

   localparam mode_type MODE_CLEAR = 2'd0;
   localparam mode_type MODE_SET   = 2'd1;
   localparam mode_type MODE_GET   = 2'd2;
   localparam mode_type MODE_DRAW  = 2'd3;

   localparam csr_idx_type CSR_LEFT_EDGE   = 2'd0;
   localparam csr_idx_type CSR_BOTTOM_EDGE = 2'd1;
   localparam csr_idx_type CSR_FG_COLOR    = 2'd2;
   localparam csr_idx_type CSR_BG_COLOR    = 2'd3;

   // octant folding of a left-to-right line
   localparam kind_type KIND_SHALLOW_UP = 2'd0;
   localparam kind_type KIND_STEEP_UP   = 2'd1;
   localparam kind_type KIND_SHALLOW_DN = 2'd2;
   localparam kind_type KIND_STEEP_DN   = 2'd3;

   localparam color_type BG_RESET = 24'hFFFFFF;

   typedef struct packed {
      logic load;
      logic clear_step;
      logic pixel;
      logic read_done;
      logic setup;
      logic prep;
      logic init;
      logic draw_step;
      logic result_load;
   } ctrl_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     clear_last;
      logic     draw_last;
   } dp_status_type;

endpackage

// ===== rtl/flr_ctrl.sv =====
// Command sequencer and result handshake of the line rasterizer.
module flr_ctrl
   import flr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  mode_type      req_mode,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_PIXEL = 4'd2;
   localparam logic [3:0] ST_READ  = 4'd3;
   localparam logic [3:0] ST_SETUP = 4'd4;
   localparam logic [3:0] ST_PREP  = 4'd5;
   localparam logic [3:0] ST_INIT  = 4'd6;
   localparam logic [3:0] ST_DRAW  = 4'd7;
   localparam logic [3:0] ST_FLUSH = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_mode)
                  MODE_CLEAR:         state_in = ST_CLEAR;
                  MODE_SET, MODE_GET: state_in = ST_PIXEL;
                  MODE_DRAW:          state_in = ST_SETUP;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_DONE;
         end
         ST_PIXEL: begin
            cmd.pixel = 1'b1;
            state_in  = (status.mode == MODE_GET) ? ST_READ : ST_DONE;
         end
         ST_READ: begin
            cmd.read_done = 1'b1;
            state_in      = ST_DONE;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_DRAW;
         end
         ST_DRAW: begin
            cmd.draw_step = 1'b1;
            if (status.draw_last) state_in = ST_FLUSH;
         end
         // last plotted pixel is written here
         ST_FLUSH: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.result_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall)          rsp_valid_in = 1'b0;
      else                          rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/flr_datapath.sv =====
// Frame store, window test, line stepper and result registers.
module flr_datapath
   import flr_pkg::*;
#(
   parameter int FRAME_WIDTH  = 64,
   parameter int FRAME_HEIGHT = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  csr_idx_type          csr_index,
   input  logic [COLOR_W-1:0]   csr_data,
   input  mode_type             req_mode,
   input  coord_type            req_first_x,
   input  coord_type            req_first_y,
   input  coord_type            req_second_x,
   input  coord_type            req_second_y,
   input  logic [CHAN_W-1:0]    req_red,
   input  logic [CHAN_W-1:0]    req_green,
   input  logic [CHAN_W-1:0]    req_blue,
   output logic [CHAN_W-1:0]    rsp_read_red,
   output logic [CHAN_W-1:0]    rsp_read_green,
   output logic [CHAN_W-1:0]    rsp_read_blue,
   output logic                 rsp_in_window,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status
);

   localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(FRAME_WIDTH);
   localparam wide_type WIN_W = WIDE_W'(FRAME_WIDTH);
   localparam wide_type WIN_H = WIDE_W'(FRAME_HEIGHT);

   // configuration
   coord_type left_ff, left_in, bottom_ff, bottom_in;
   color_type fg_ff, fg_in, bg_ff, bg_in;

   always_comb begin
      left_in   = left_ff;
      bottom_in = bottom_ff;
      fg_in     = fg_ff;
      bg_in     = bg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LEFT_EDGE:   left_in   = csr_data[COORD_W-1:0];
            CSR_BOTTOM_EDGE: bottom_in = csr_data[COORD_W-1:0];
            CSR_FG_COLOR:    fg_in     = csr_data;
            CSR_BG_COLOR:    bg_in     = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         bottom_ff <= '0;
         fg_ff     <= '0;
         bg_ff     <= BG_RESET;
      end else begin
         left_ff   <= left_in;
         bottom_ff <= bottom_in;
         fg_ff     <= fg_in;
         bg_ff     <= bg_in;
      end
   end

   // captured item
   mode_type  mode_ff, mode_in;
   coord_type fx_ff, fx_in, fy_ff, fy_in, sx_ff, sx_in, sy_ff, sy_in;
   color_type color_ff, color_in;

   always_comb begin
      mode_in  = mode_ff;
      fx_in    = fx_ff;
      fy_in    = fy_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      color_in = color_ff;
      if (cmd.load) begin
         mode_in  = req_mode;
         fx_in    = req_first_x;
         fy_in    = req_first_y;
         sx_in    = req_second_x;
         sy_in    = req_second_y;
         color_in = {req_red, req_green, req_blue};
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      color_ff <= color_in;
   end

   // setup: order endpoints left to right
   coord_type ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   diff_type  dx_ff, dx_in, dy_ff, dy_in;
   diff_type  diff_x, diff_y;
   logic      swap;

   always_comb begin
      diff_x = DIFF_W'(sx_ff) - DIFF_W'(fx_ff);
      diff_y = DIFF_W'(sy_ff) - DIFF_W'(fy_ff);
      swap   = diff_x[DIFF_W-1];
      ax_in  = ax_ff;
      ay_in  = ay_ff;
      bx_in  = bx_ff;
      by_in  = by_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      if (cmd.setup) begin
         ax_in = swap ? sx_ff : fx_ff;
         ay_in = swap ? sy_ff : fy_ff;
         bx_in = swap ? fx_ff : sx_ff;
         by_in = swap ? fy_ff : sy_ff;
         dx_in = swap ? -diff_x : diff_x;
         dy_in = swap ? -diff_y : diff_y;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
   end

   // prep: octant fold; init: decision terms; draw: one pixel per cycle
   kind_type kind_ff, kind_in;
   wide_type u_ff, u_in, v_ff, v_in, u1_ff, u1_in, anchor_ff, anchor_in;
   diff_type dxk_ff, dxk_in, dyk_ff, dyk_in;
   wide_type d_ff, d_in, e_ff, e_in, ne_ff, ne_in;
   wide_type plot_x_ff, plot_x_in, plot_y_ff, plot_y_in;
   logic     plot_vld_ff;
   diff_type neg_dy;
   wide_type dxk_w, dyk_w, mirror;

   always_comb begin
      neg_dy    = -dy_ff;
      dxk_w     = WIDE_W'(dxk_ff);
      dyk_w     = WIDE_W'(dyk_ff);
      mirror    = anchor_ff + anchor_ff - v_ff;
      kind_in   = kind_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      u1_in     = u1_ff;
      anchor_in = anchor_ff;
      dxk_in    = dxk_ff;
      dyk_in    = dyk_ff;
      d_in      = d_ff;
      e_in      = e_ff;
      ne_in     = ne_ff;
      plot_x_in = plot_x_ff;
      plot_y_in = plot_y_ff;
      if (cmd.prep) begin
         priority if (!dy_ff[DIFF_W-1] && dx_ff >= dy_ff) begin
            kind_in = KIND_SHALLOW_UP;
            u_in    = WIDE_W'(ax_ff);
            v_in    = WIDE_W'(ay_ff);
            u1_in   = WIDE_W'(bx_ff);
            dxk_in  = dx_ff;
            dyk_in  = dy_ff;
         end else if (!dy_ff[DIFF_W-1]) begin
            kind_in = KIND_STEEP_UP;
            u_in    = WIDE_W'(ay_ff);
            v_in    = WIDE_W'(ax_ff);
            u1_in   = WIDE_W'(by_ff);
            dxk_in  = dy_ff;
            dyk_in  = dx_ff;
         end else if (dx_ff >= neg_dy) begin
            kind_in = KIND_SHALLOW_DN;
            u_in    = WIDE_W'(ax_ff);
            v_in    = WIDE_W'(ay_ff);
            u1_in   = WIDE_W'(bx_ff);
            dxk_in  = dx_ff;
            dyk_in  = neg_dy;
         end else begin
            kind_in = KIND_STEEP_DN;
            u_in    = WIDE_W'(by_ff);
            v_in    = WIDE_W'(bx_ff);
            u1_in   = WIDE_W'(ay_ff);
            dxk_in  = neg_dy;
            dyk_in  = dx_ff;
         end
         anchor_in = v_in;
      end
      if (cmd.init) begin
         e_in  = dyk_w + dyk_w;
         d_in  = dyk_w + dyk_w - dxk_w;
         ne_in = dyk_w + dyk_w - dxk_w - dxk_w;
      end
      if (cmd.draw_step) begin
         unique case (kind_ff)
            KIND_SHALLOW_UP: begin plot_x_in = u_ff;   plot_y_in = v_ff;   end
            KIND_STEEP_UP:   begin plot_x_in = v_ff;   plot_y_in = u_ff;   end
            KIND_SHALLOW_DN: begin plot_x_in = u_ff;   plot_y_in = mirror; end
            KIND_STEEP_DN:   begin plot_x_in = mirror; plot_y_in = u_ff;   end
         endcase
         if (d_ff[WIDE_W-1] || d_ff == '0) begin
            d_in = d_ff + e_ff;
         end else begin
            d_in = d_ff + ne_ff;
            v_in = v_ff + WIDE_W'(1);
         end
         u_in = u_ff + WIDE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      u1_ff     <= u1_in;
      anchor_ff <= anchor_in;
      dxk_ff    <= dxk_in;
      dyk_ff    <= dyk_in;
      d_ff      <= d_in;
      e_ff      <= e_in;
      ne_ff     <= ne_in;
      plot_x_ff <= plot_x_in;
      plot_y_ff <= plot_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) plot_vld_ff <= 1'b0;
      else       plot_vld_ff <= cmd.draw_step;
   end

   // window test and address: the plot stage has priority over the item pixel
   wide_type            loc_x, loc_y, cx, cy;
   logic                in_win;
   logic [ADDR_W-1:0]   slot;

   always_comb begin
      loc_x  = plot_vld_ff ? plot_x_ff : WIDE_W'(fx_ff);
      loc_y  = plot_vld_ff ? plot_y_ff : WIDE_W'(fy_ff);
      cx     = loc_x - WIDE_W'(left_ff);
      cy     = loc_y - WIDE_W'(bottom_ff);
      in_win = !cx[WIDE_W-1] && (cx < WIN_W) && !cy[WIDE_W-1] && (cy < WIN_H);
      slot   = ADDR_W'(cx) + ADDR_W'(cy) * ROW_STRIDE;
   end

   // clear sweep
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      priority if (cmd.load)    clr_addr_in = '0;
      else if (cmd.clear_step)  clr_addr_in = clr_addr_ff + ADDR_W'(1);
      else                      clr_addr_in = clr_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_addr_ff <= '0;
      else       clr_addr_ff <= clr_addr_in;
   end

   // frame store, single write port, registered read
   color_type         frame_store_ff [DEPTH];
   color_type         rd_data_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   color_type         wr_data;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot;
      wr_data = fg_ff;
      priority if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = bg_ff;
      end else if (cmd.pixel && mode_ff == MODE_SET) begin
         wr_en   = in_win;
         wr_data = color_ff;
      end else if (plot_vld_ff) begin
         wr_en   = in_win;
      end else begin
         wr_en   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) frame_store_ff[wr_addr] <= wr_data;
      rd_data_ff <= frame_store_ff[slot];
   end

   // result
   color_type res_color_ff, res_color_in, out_color_ff, out_color_in;
   logic      res_inside_ff, res_inside_in, out_inside_ff, out_inside_in;

   always_comb begin
      res_color_in  = res_color_ff;
      res_inside_in = res_inside_ff;
      out_color_in  = out_color_ff;
      out_inside_in = out_inside_ff;
      if (cmd.load) begin
         res_color_in  = '0;
         res_inside_in = 1'b0;
      end
      if (cmd.pixel)       res_inside_in = in_win;
      if (cmd.read_done)   res_color_in  = res_inside_ff ? rd_data_ff : '0;
      if (cmd.result_load) begin
         out_color_in  = res_color_ff;
         out_inside_in = res_inside_ff;
      end
   end

   always_ff @(posedge clock) begin
      res_color_ff  <= res_color_in;
      res_inside_ff <= res_inside_in;
      out_color_ff  <= out_color_in;
      out_inside_ff <= out_inside_in;
   end

   assign rsp_read_red   = out_color_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp_read_green = out_color_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_read_blue  = out_color_ff[CHAN_W-1:0];
   assign rsp_in_window  = out_inside_ff;

   assign status.mode       = mode_ff;
   assign status.clear_last = (clr_addr_ff == LAST_ADDR);
   assign status.draw_last  = (u_ff == u1_ff);

endmodule

// ===== rtl/framebuffer_line_rasterizer.sv =====
// Top level of the frame store line rasterizer.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   mode, first/second x y, red green blue
//   rsp_      out        rsp_valid/rsp_stall   read_red/green/blue, in_window
//   csr_      in         csr_write             csr_index, csr_data
//
// Clear sweeps all FRAME_WIDTH*FRAME_HEIGHT entries (one frame store write per cycle);
// draw steps along the line (the line stepper plots one pixel per cycle).
// Synchronous active-high reset; the frame store is not cleared by reset.
// A new item is taken while a finished result still waits on rsp_stall;
// only its own result then waits for the output register to drain.
module framebuffer_line_rasterizer
   import flr_pkg::*;
#(
   parameter int FRAME_WIDTH  = 64,
   parameter int FRAME_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  csr_idx_type        csr_index,
   input  logic [COLOR_W-1:0] csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  mode_type           req_mode,
   input  coord_type          req_first_x,
   input  coord_type          req_first_y,
   input  coord_type          req_second_x,
   input  coord_type          req_second_y,
   input  logic [CHAN_W-1:0]  req_red,
   input  logic [CHAN_W-1:0]  req_green,
   input  logic [CHAN_W-1:0]  req_blue,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAN_W-1:0]  rsp_read_red,
   output logic [CHAN_W-1:0]  rsp_read_green,
   output logic [CHAN_W-1:0]  rsp_read_blue,
   output logic               rsp_in_window
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   flr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   flr_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_mode       (req_mode),
      .req_first_x    (req_first_x),
      .req_first_y    (req_first_y),
      .req_second_x   (req_second_x),
      .req_second_y   (req_second_y),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_read_red   (rsp_read_red),
      .rsp_read_green (rsp_read_green),
      .rsp_read_blue  (rsp_read_blue),
      .rsp_in_window  (rsp_in_window),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

// ===== rtl/flr_checker.sv =====
// Port-level checks of the line rasterizer, bound to its top level.
`include "framebuffer_line_rasterizer_macros.svh"

module flr_checker
   import flr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CHAN_W-1:0] rsp_read_red,
   input logic [CHAN_W-1:0] rsp_read_green,
   input logic [CHAN_W-1:0] rsp_read_blue,
   input logic              rsp_in_window
);

   logic [3*CHAN_W-1:0] rsp_color;

   assign rsp_color = {rsp_read_red, rsp_read_green, rsp_read_blue};

   `FLR_ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_valid)
   `FLR_ASSERT(a_rsp_held, rsp_valid && rsp_stall |=> rsp_valid)
   `FLR_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall)
   // a fresh result only comes out of a busy period
   `FLR_ASSERT(a_rsp_from_work, $rose(rsp_valid) |-> $past(req_stall))
   `FLR_ASSERT(a_outside_is_black, rsp_valid && !rsp_in_window |-> rsp_color == '0)

endmodule

bind framebuffer_line_rasterizer flr_checker u_flr_checker (.*);

// ===== tb/tb_framebuffer_line_rasterizer.sv =====
// Self-checking testbench for the frame store line rasterizer: directed table plus random commands.
`timescale 1ns / 1ps

module tb_framebuffer_line_rasterizer;
   import flr_pkg::*;

   localparam int FRAME_W     = 64;
   localparam int FRAME_H     = 64;
   localparam int STORE_DEPTH = FRAME_W * FRAME_H;
   localparam int COORD_MIN   = -(1 << (COORD_W - 1));
   localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 54;
   // clears and full-range lines are costly; both are capped
   localparam int MAX_CLEARS  = 14;
   localparam int MAX_LONG    = 14;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              in_window;
   } readback_type;

   typedef struct {
      mode_type     mode;
      int           fx;
      int           fy;
      int           sx;
      int           sy;
      color_type    rgb;
      bit           typed;
      readback_type want;
   } command_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   csr_idx_type        csr_index = CSR_LEFT_EDGE;
   logic [COLOR_W-1:0] csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   mode_type           req_mode = MODE_CLEAR;
   coord_type          req_first_x = '0;
   coord_type          req_first_y = '0;
   coord_type          req_second_x = '0;
   coord_type          req_second_y = '0;
   logic [CHAN_W-1:0]  req_red = '0;
   logic [CHAN_W-1:0]  req_green = '0;
   logic [CHAN_W-1:0]  req_blue = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [CHAN_W-1:0]  rsp_read_red;
   logic [CHAN_W-1:0]  rsp_read_green;
   logic [CHAN_W-1:0]  rsp_read_blue;
   logic               rsp_in_window;

   framebuffer_line_rasterizer #(
      .FRAME_WIDTH  (FRAME_W),
      .FRAME_HEIGHT (FRAME_H)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_first_x    (req_first_x),
      .req_first_y    (req_first_y),
      .req_second_x   (req_second_x),
      .req_second_y   (req_second_y),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_red   (rsp_read_red),
      .rsp_read_green (rsp_read_green),
      .rsp_read_blue  (rsp_read_blue),
      .rsp_in_window  (rsp_in_window)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // pixel store and window registers as the block should hold them
   color_type frame_model [STORE_DEPTH];
   int        win_left = 0;
   int        win_bottom = 0;
   color_type fg_color = '0;
   color_type bg_color = BG_RESET;

   readback_type readback_q [$];
   command_type  directed_rows [$];
   int           recent_x [$];
   int           recent_y [$];

   int  error_count = 0;
   int  results_seen = 0;
   int  cycle_count = 0;
   int  mode_count [4];
   int  gets_inside = 0;
   int  long_lines = 0;
   int  clears_left = MAX_CLEARS;
   int  long_left = MAX_LONG;
   int  settings_used = 1;
   int  stall_burst = 0;
   bit  quiet_tail = 1'b0;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic bit calm_stretch();
      return (cycle_count % 1200) >= 900;
   endfunction

   function automatic int clamp12(int v);
      return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   function automatic int rand12();
      return int'(coord_type'($urandom));
   endfunction

   // coordinate in or just around the current window
   function automatic int near_window(int base);
      int lo, hi;
      lo = clamp12(base - 8);
      hi = clamp12(base + FRAME_W + 7);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic bit window_slot(int x, int y, output int slot);
      int cx, cy;
      cx = x - win_left;
      cy = y - win_bottom;
      slot = cx + cy * FRAME_W;
      return cx >= 0 && cx < FRAME_W && cy >= 0 && cy < FRAME_H;
   endfunction

   function automatic bit plot_pixel(int x, int y, color_type color);
      int slot;
      if (!window_slot(x, y, slot))
         return 1'b0;
      frame_model[slot] = color;
      return 1'b1;
   endfunction

   // midpoint line, folded into one of four octant cases
   function automatic void trace_line(int ax, int ay, int bx, int by);
      int u0, v0, u1, dx, dy, d, e_step, ne_step, u, v, anchor, t;
      kind_type kind;
      if (ax > bx) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = by - ay;
      if (dy >= 0 && dx >= dy) begin
         kind = KIND_SHALLOW_UP;
         u0 = ax; v0 = ay; u1 = bx;
      end else if (dy >= 0) begin
         kind = KIND_STEEP_UP;
         u0 = ay; v0 = ax; u1 = by;
         dx = by - ay;
         dy = bx - ax;
      end else if (dx >= -dy) begin
         kind = KIND_SHALLOW_DN;
         u0 = ax; v0 = ay; u1 = bx;
         dy = -dy;
      end else begin
         kind = KIND_STEEP_DN;
         u0 = by; v0 = bx; u1 = ay;
         dx = ay - by;
         dy = bx - ax;
      end
      d = 2 * dy - dx;
      e_step = 2 * dy;
      ne_step = 2 * (dy - dx);
      anchor = v0;
      v = v0;
      for (u = u0; u <= u1; u++) begin
         case (kind)
            KIND_SHALLOW_UP: void'(plot_pixel(u, v, fg_color));
            KIND_STEEP_UP:   void'(plot_pixel(v, u, fg_color));
            KIND_SHALLOW_DN: void'(plot_pixel(u, 2 * anchor - v, fg_color));
            default:         void'(plot_pixel(2 * anchor - v, u, fg_color));
         endcase
         if (d <= 0) begin
            d += e_step;
         end else begin
            d += ne_step;
            v++;
         end
      end
   endfunction

   function automatic readback_type rasterize(command_type c);
      readback_type r;
      int slot;
      r = '0;
      case (c.mode)
         MODE_CLEAR: foreach (frame_model[i]) frame_model[i] = bg_color;
         MODE_SET:   r.in_window = plot_pixel(c.fx, c.fy, c.rgb);
         MODE_GET: begin
            if (window_slot(c.fx, c.fy, slot)) begin
               {r.red, r.green, r.blue} = frame_model[slot];
               r.in_window = 1'b1;
               gets_inside++;
            end
         end
         default: trace_line(c.fx, c.fy, c.sx, c.sy);
      endcase
      return r;
   endfunction

   function automatic void add_row(mode_type mode, int fx, int fy, int sx, int sy,
                                   color_type rgb, bit typed, color_type want_rgb,
                                   logic want_in);
      command_type c;
      c.mode = mode;
      c.fx = fx;
      c.fy = fy;
      c.sx = sx;
      c.sy = sy;
      c.rgb = rgb;
      c.typed = typed;
      c.want = {want_rgb, want_in};
      directed_rows.push_back(c);
   endfunction

   function automatic void remember_point(int x, int y);
      recent_x.push_back(x);
      recent_y.push_back(y);
      if (recent_x.size() > 32) begin
         recent_x.pop_front();
         recent_y.pop_front();
      end
   endfunction

   function automatic command_type random_command();
      command_type c;
      int pick, k;
      c.typed = 1'b0;
      c.want = '0;
      c.rgb = color_type'($urandom);
      // unused fields still toggle over their full range
      c.sx = rand12();
      c.sy = rand12();
      c.fx = near_window(win_left);
      c.fy = near_window(win_bottom);
      pick = $urandom_range(99);
      if (pick < 3 && clears_left > 0) begin
         c.mode = MODE_CLEAR;
         clears_left--;
      end else if (pick < 35) begin
         c.mode = MODE_SET;
         if ($urandom_range(99) < 15) begin
            c.fx = rand12();
            c.fy = rand12();
         end
         remember_point(c.fx, c.fy);
      end else if (pick < 68) begin
         c.mode = MODE_GET;
         if ($urandom_range(99) < 12) begin
            c.fx = rand12();
            c.fy = rand12();
         end else if (recent_x.size() > 0 && $urandom_range(1) == 1) begin
            k = $urandom_range(recent_x.size() - 1);
            c.fx = recent_x[k];
            c.fy = recent_y[k];
         end
      end else begin
         c.mode = MODE_DRAW;
         if (long_left > 0 && $urandom_range(99) < 5) begin
            c.fx = rand12();
            c.fy = rand12();
            long_left--;
            long_lines++;
         end else begin
            c.sx = clamp12(c.fx + int'($urandom_range(144)) - 72);
            c.sy = clamp12(c.fy + int'($urandom_range(144)) - 72);
         end
         remember_point(c.fx, c.fy);
         remember_point(c.sx, c.sy);
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
      error_count++;
   endtask

   // leaves req_valid high; the caller either sends again or drops it
   task automatic send_command(command_type c);
      readback_type want;
      want = rasterize(c);
      if (c.typed)
         want = c.want;
      readback_q.push_back(want);
      req_valid <= 1'b1;
      req_mode <= c.mode;
      req_first_x <= coord_type'(c.fx);
      req_first_y <= coord_type'(c.fy);
      req_second_x <= coord_type'(c.sx);
      req_second_y <= coord_type'(c.sy);
      {req_red, req_green, req_blue} <= c.rgb;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      mode_count[c.mode]++;
   endtask

   task automatic maybe_pause();
      if (!quiet_tail && !calm_stretch() && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (readback_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= color_type'(value);
      case (idx)
         CSR_LEFT_EDGE:   win_left = int'(coord_type'(value));
         CSR_BOTTOM_EDGE: win_bottom = int'(coord_type'(value));
         CSR_FG_COLOR:    fg_color = color_type'(value);
         default:         bg_color = color_type'(value);
      endcase
      @(posedge clock);
   endtask

   task automatic set_window(int left, int bottom, color_type fg, color_type bg);
      wait_idle();
      write_reg(CSR_LEFT_EDGE, left);
      write_reg(CSR_BOTTOM_EDGE, bottom);
      write_reg(CSR_FG_COLOR, int'(fg));
      write_reg(CSR_BG_COLOR, int'(bg));
      csr_write <= 1'b0;
      settings_used++;
   endtask

   // receiver: random stall bursts
   always @(posedge clock) begin
      if (stall_burst == 0 && !quiet_tail && !calm_stretch() && $urandom_range(99) < 15)
         stall_burst = $urandom_range(5, 1);
      if (stall_burst > 0) begin
         rsp_stall <= 1'b1;
         stall_burst = stall_burst - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : rsp_check
      readback_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (readback_q.size() == 0) begin
            report_mismatch("arrived with nothing pending",
                            {rsp_read_red, rsp_read_green, rsp_read_blue}, 0);
         end else begin
            want = readback_q.pop_front();
            if (rsp_read_red !== want.red)
               report_mismatch("read_red", rsp_read_red, want.red);
            if (rsp_read_green !== want.green)
               report_mismatch("read_green", rsp_read_green, want.green);
            if (rsp_read_blue !== want.blue)
               report_mismatch("read_blue", rsp_read_blue, want.blue);
            if (rsp_in_window !== want.in_window)
               report_mismatch("in_window", rsp_in_window, want.in_window);
         end
         results_seen++;
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TIMEOUT after %0d cycles, %0d results pending", cycle_count, readback_q.size());
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int phase;
      foreach (mode_count[i]) mode_count[i] = 0;

      // window at reset: (0,0)..(63,63), fg black, bg white
      add_row(MODE_GET, -1, 0, 0, 0, 24'h000000, 1, 24'h000000, 1'b0);
      add_row(MODE_GET, FRAME_W, 5, 0, 0, 24'h000000, 1, 24'h000000, 1'b0);
      add_row(MODE_GET, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 24'hFFFFFF,
              1, 24'h000000, 1'b0);
      add_row(MODE_SET, 0, 0, COORD_MAX, COORD_MIN, 24'h123456, 1, 24'h000000, 1'b1);
      add_row(MODE_SET, COORD_MIN, COORD_MIN, 0, 0, 24'hFFFFFF, 1, 24'h000000, 1'b0);
      add_row(MODE_SET, COORD_MAX, COORD_MAX, -1, -1, 24'h000000, 1, 24'h000000, 1'b0);
      add_row(MODE_CLEAR, 0, 0, 0, 0, 24'h000000, 1, 24'h000000, 1'b0);
      add_row(MODE_GET, 0, 0, 0, 0, 24'h000000, 1, 24'hFFFFFF, 1'b1);
      add_row(MODE_GET, FRAME_W - 1, FRAME_H - 1, 0, 0, 24'h000000, 1, 24'hFFFFFF, 1'b1);
      add_row(MODE_SET, FRAME_W - 1, 0, 0, 0, 24'hFF00AA, 1, 24'h000000, 1'b1);
      add_row(MODE_GET, FRAME_W - 1, 0, 0, 0, 24'h000000, 1, 24'hFF00AA, 1'b1);
      add_row(MODE_SET, 0, FRAME_H - 1, 0, 0, 24'h00FF55, 1, 24'h000000, 1'b1);
      add_row(MODE_GET, 0, FRAME_H - 1, 0, 0, 24'h000000, 1, 24'h00FF55, 1'b1);
      add_row(MODE_SET, FRAME_W, FRAME_H - 1, 0, 0, 24'hABCDEF, 1, 24'h000000, 1'b0);
      // one line per octant case, then a single point and a full-range diagonal
      // that crosses the window
      add_row(MODE_DRAW, 2, 3, 20, 9, 24'h000000, 1, 24'h000000, 1'b0);
      add_row(MODE_GET, 11, 6, 0, 0, 24'h000000, 0, 24'h000000, 1'b0);
      add_row(MODE_DRAW, 5, 5, 9, 30, 24'h000000, 1, 24'h000000, 1'b0);
      add_row(MODE_GET, 7, 17, 0, 0, 24'h000000, 0, 24'h000000, 1'b0);
      add_row(MODE_DRAW, 60, 44, 40, 50, 24'h000000, 1, 24'h000000, 1'b0);
      add_row(MODE_GET, 50, 47, 0, 0, 24'h000000, 0, 24'h000000, 1'b0);
      add_row(MODE_DRAW, 30, 10, 25, 40, 24'h000000, 1, 24'h000000, 1'b0);
      add_row(MODE_GET, 27, 25, 0, 0, 24'h000000, 0, 24'h000000, 1'b0);
      add_row(MODE_DRAW, 10, 10, 10, 10, 24'h000000, 1, 24'h000000, 1'b0);
      add_row(MODE_DRAW, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 24'h000000,
              1, 24'h000000, 1'b0);
      add_row(MODE_GET, 33, 33, 0, 0, 24'h000000, 1, 24'h000000, 1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_command(directed_rows[i]);
         maybe_pause();
      end

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_window(COORD_MIN, COORD_MAX, 24'hFFFFFF, 24'h000000);
            1: set_window(COORD_MAX, COORD_MIN, 24'h000000, 24'hFFFFFF);
            2: set_window(int'($urandom_range(200)) - 100, int'($urandom_range(200)) - 100,
                          color_type'($urandom), color_type'($urandom));
            3: set_window(rand12(), rand12(), color_type'($urandom), color_type'($urandom));
            4: set_window(0, 0, color_type'($urandom), color_type'($urandom));
            5: set_window(-FRAME_W / 2, -FRAME_H / 2, color_type'($urandom),
                          color_type'($urandom));
            default: set_window(int'($urandom_range(40)) - 20, int'($urandom_range(40)) - 20,
                                color_type'($urandom), color_type'($urandom));
         endcase
         quiet_tail = (phase == PHASES - 1);
         repeat (PHASE_ITEMS) begin
            send_command(random_command());
            // now and then hold off until everything outstanding has drained
            if (!quiet_tail && $urandom_range(99) < 2)
               wait_idle();
            else
               maybe_pause();
         end
      end
      wait_idle();

      $display("Covered %0d clears, %0d sets, %0d gets (%0d in window), %0d draws (%0d long)",
               mode_count[MODE_CLEAR], mode_count[MODE_SET], mode_count[MODE_GET],
               gets_inside, mode_count[MODE_DRAW], long_lines);
      $display("over %0d window and color settings; %0d results checked, %0d mismatches",
               settings_used, results_seen, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
